FILE: rtl/particle_drift_periodic_wrap_top_assert.svh
// Assertion macros for the particle drift checker.
// Expects clk and arst_n in the scope of the use.
`ifndef PARTICLE_DRIFT_PERIODIC_WRAP_TOP_ASSERT_SVH
`define PARTICLE_DRIFT_PERIODIC_WRAP_TOP_ASSERT_SVH

// same-cycle implication
`define PDW_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("pdw check failed");

// next-cycle implication
`define PDW_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("pdw check failed");

`endif

FILE: rtl/pdw_pkg.sv
// Shared types, constants and helper functions of the particle drift block.
// No dependencies.
package pdw_pkg;

	localparam int FRAC_BITS = 20;
	localparam int FACT_FRAC = 24;
	localparam int MAX_BOX   = 4096;
	localparam int MID_DEPTH = 4;
	localparam int OUT_DEPTH = 8;
	localparam int CFG_IDX_W = 3;

	localparam logic [CFG_IDX_W-1:0] CFG_DRIFT_FACTOR = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BOX_X        = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_BOX_Y        = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_BOX_Z        = 3'd3;

	localparam logic [31:0] DRIFT_RESET = 32'h0100_0000;
	localparam logic [12:0] BOX_RESET   = 13'd256;

	typedef logic [12:0] box_t;
	typedef logic [32:0] span_t;

	typedef struct packed {
		logic [31:0] drift_factor;
		box_t        box_x;
		box_t        box_y;
		box_t        box_z;
	} cfg_t;

	typedef struct packed {
		logic signed [31:0] vel_x;
		logic signed [31:0] vel_y;
		logic signed [31:0] vel_z;
		logic               last;
	} vel_t;

	// box in whole cells, clamped to [1, MAX_BOX], in Q20 units
	function automatic span_t box_span(box_t cells);
		box_t c;
		if (cells == 13'd0) begin
			c = 13'd1;
		end else if (cells > 13'(MAX_BOX)) begin
			c = 13'(MAX_BOX);
		end else begin
			c = cells;
		end
		return {c, {FRAC_BITS{1'b0}}};
	endfunction

	function automatic logic [63:0] sat_add(logic [63:0] a, logic [63:0] b);
		logic [64:0] r;
		r = {1'b0, a} + {1'b0, b};
		return r[64] ? {64{1'b1}} : r[63:0];
	endfunction

endpackage

FILE: rtl/particle_drift_periodic_wrap_top.sv
// Top level of the particle drift step with periodic wrap: configuration
// registers, front queue and back pipe. Uses pdw_pkg, pdw_front, pdw_back.
//
//  channel   handshake              payload
//  input     push / full            pos_x pos_y pos_z vel_x vel_y vel_z last
//  result    empty / pop            new_pos_x new_pos_y new_pos_z max_disp_sq batch_end
//  config    cfg_valid / cfg_ready  cfg_index cfg_data
//
// One particle per cycle sustained while the result side keeps up; a particle
// passes the front queue, six pipe stages and the output queue to the result side.
// Issue from the front queue is limited by an 8-entry credit window on the
// output queue; a stalled result side fills it, then the 4-entry front queue.
// Reset loads the register defaults, empties both queues and clears the maximum.
module particle_drift_periodic_wrap_top #(
	parameter int POS_WIDTH = 32
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               push,
	output logic                               full,
	input  logic [31:0]                        pos_x,
	input  logic [31:0]                        pos_y,
	input  logic [31:0]                        pos_z,
	input  logic signed [31:0]                 vel_x,
	input  logic signed [31:0]                 vel_y,
	input  logic signed [31:0]                 vel_z,
	input  logic                               last,
	output logic                               empty,
	input  logic                               pop,
	output logic [31:0]                        new_pos_x,
	output logic [31:0]                        new_pos_y,
	output logic [31:0]                        new_pos_z,
	output logic [63:0]                        max_disp_sq,
	output logic                               batch_end,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [pdw_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [31:0]                        cfg_data
);

	localparam int PW = (POS_WIDTH < 32) ? POS_WIDTH : 32;

	pdw_pkg::cfg_t cfg_q;
	pdw_pkg::vel_t in_vel;
	pdw_pkg::vel_t q_vel;
	logic          q_valid;
	logic          q_take;
	logic [PW-1:0] q_pos_x, q_pos_y, q_pos_z;
	logic [PW-1:0] bk_pos_x, bk_pos_y, bk_pos_z;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.drift_factor <= pdw_pkg::DRIFT_RESET;
			cfg_q.box_x        <= pdw_pkg::BOX_RESET;
			cfg_q.box_y        <= pdw_pkg::BOX_RESET;
			cfg_q.box_z        <= pdw_pkg::BOX_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				pdw_pkg::CFG_DRIFT_FACTOR: cfg_q.drift_factor <= cfg_data;
				pdw_pkg::CFG_BOX_X:        cfg_q.box_x <= cfg_data[12:0];
				pdw_pkg::CFG_BOX_Y:        cfg_q.box_y <= cfg_data[12:0];
				pdw_pkg::CFG_BOX_Z:        cfg_q.box_z <= cfg_data[12:0];
				default: cfg_q <= cfg_q;
			endcase
		end
	end

	assign in_vel.vel_x = vel_x;
	assign in_vel.vel_y = vel_y;
	assign in_vel.vel_z = vel_z;
	assign in_vel.last  = last;

	pdw_front #(.PW(PW)) u_front (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full),
		.pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z), .vel(in_vel),
		.q_valid(q_valid), .q_pos_x(q_pos_x), .q_pos_y(q_pos_y), .q_pos_z(q_pos_z),
		.q_vel(q_vel), .q_take(q_take)
	);

	pdw_back #(.PW(PW)) u_back (
		.clk(clk), .arst_n(arst_n), .cfg(cfg_q),
		.q_valid(q_valid), .q_pos_x(q_pos_x), .q_pos_y(q_pos_y), .q_pos_z(q_pos_z),
		.q_vel(q_vel), .q_take(q_take),
		.pop(pop), .empty(empty),
		.new_pos_x(bk_pos_x), .new_pos_y(bk_pos_y), .new_pos_z(bk_pos_z),
		.max_disp_sq(max_disp_sq), .batch_end(batch_end)
	);

	assign new_pos_x = 32'(bk_pos_x);
	assign new_pos_y = 32'(bk_pos_y);
	assign new_pos_z = 32'(bk_pos_z);

endmodule

FILE: rtl/pdw_front.sv
// Front end: takes particles from the input queue port, masks positions
// and holds them in a short queue for the back end. Uses pdw_pkg.
module pdw_front #(
	parameter int PW = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  logic [31:0]       pos_x,
	input  logic [31:0]       pos_y,
	input  logic [31:0]       pos_z,
	input  pdw_pkg::vel_t     vel,
	output logic              q_valid,
	output logic [PW-1:0]     q_pos_x,
	output logic [PW-1:0]     q_pos_y,
	output logic [PW-1:0]     q_pos_z,
	output pdw_pkg::vel_t     q_vel,
	input  logic              q_take
);

	localparam int AW = $clog2(pdw_pkg::MID_DEPTH);
	localparam int CW = $clog2(pdw_pkg::MID_DEPTH + 1);

	logic [PW-1:0]  px_q [pdw_pkg::MID_DEPTH];
	logic [PW-1:0]  py_q [pdw_pkg::MID_DEPTH];
	logic [PW-1:0]  pz_q [pdw_pkg::MID_DEPTH];
	pdw_pkg::vel_t  vel_q [pdw_pkg::MID_DEPTH];
	logic [AW-1:0]  wr_ptr_q;
	logic [AW-1:0]  rd_ptr_q;
	logic [CW-1:0]  cnt_q;
	logic           wr;

	assign full = (cnt_q == CW'(pdw_pkg::MID_DEPTH));
	assign wr = push && !full;
	assign q_valid = (cnt_q != '0);

	assign q_pos_x = px_q[rd_ptr_q];
	assign q_pos_y = py_q[rd_ptr_q];
	assign q_pos_z = pz_q[rd_ptr_q];
	assign q_vel   = vel_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr) begin
			px_q[wr_ptr_q]  <= pos_x[PW-1:0];
			py_q[wr_ptr_q]  <= pos_y[PW-1:0];
			pz_q[wr_ptr_q]  <= pos_z[PW-1:0];
			vel_q[wr_ptr_q] <= vel;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (wr) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (q_take) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			unique case ({wr, q_take})
				2'b10: cnt_q <= cnt_q + 1'b1;
				2'b01: cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

FILE: rtl/pdw_axis.sv
// One axis of the drift: velocity times factor, floor shift, clamp to the
// box, periodic wrap and squared displacement. Four register stages. Uses pdw_pkg.
module pdw_axis #(
	parameter int PW = 32
) (
	input  logic                clk,
	input  logic [PW-1:0]       pos,
	input  logic signed [31:0]  vel,
	input  logic [31:0]         factor,
	input  pdw_pkg::span_t      span,
	output logic [PW-1:0]       new_pos,
	output logic [63:0]         sq
);

	logic signed [64:0] prod_w;
	logic signed [63:0] prod_s1;
	logic [PW-1:0]      pos_s1;

	logic signed [39:0] dr_w;
	logic signed [40:0] dr41_w;
	logic signed [40:0] spn41_w;
	logic signed [40:0] dc_w;
	logic signed [33:0] d_s2;
	logic [PW-1:0]      pos_s2;

	logic signed [33:0] ad_w;
	logic signed [35:0] sum_w;
	logic [32:0]        ad_s3;
	logic signed [35:0] sum_s3;

	logic signed [35:0] spn36_w;
	logic signed [35:0] wrap_w;
	logic [PW-1:0]      pos_s4;
	logic [63:0]        sq_s4;

	// stage 1: signed 32 x unsigned 32 product
	assign prod_w = 65'(vel) * 65'($signed({1'b0, factor}));

	always_ff @(posedge clk) begin
		prod_s1 <= $signed(prod_w[63:0]);
		pos_s1  <= pos;
	end

	// stage 2: arithmetic shift is the floor division; clamp to +/- span
	always_comb begin
		dr_w    = $signed(prod_s1[63:pdw_pkg::FACT_FRAC]);
		dr41_w  = 41'(dr_w);
		spn41_w = $signed(41'(span));
		priority if (dr41_w > spn41_w) begin
			dc_w = spn41_w;
		end else if (dr41_w < -spn41_w) begin
			dc_w = -spn41_w;
		end else begin
			dc_w = dr41_w;
		end
	end

	always_ff @(posedge clk) begin
		d_s2   <= dc_w[33:0];
		pos_s2 <= pos_s1;
	end

	// stage 3: magnitude and raw sum
	always_comb begin
		ad_w  = d_s2[33] ? -d_s2 : d_s2;
		sum_w = $signed(36'(pos_s2)) + $signed(36'(d_s2));
	end

	always_ff @(posedge clk) begin
		ad_s3  <= ad_w[32:0];
		sum_s3 <= sum_w;
	end

	// stage 4: single wrap and square; magnitude 2^32 saturates
	always_comb begin
		spn36_w = $signed(36'(span));
		priority if (sum_s3 < 0) begin
			wrap_w = sum_s3 + spn36_w;
		end else if (sum_s3 >= spn36_w) begin
			wrap_w = sum_s3 - spn36_w;
		end else begin
			wrap_w = sum_s3;
		end
	end

	always_ff @(posedge clk) begin
		pos_s4 <= wrap_w[PW-1:0];
		sq_s4  <= ad_s3[32] ? {64{1'b1}} : 64'(ad_s3[31:0]) * 64'(ad_s3[31:0]);
	end

	assign new_pos = pos_s4;
	assign sq      = sq_s4;

endmodule

FILE: rtl/pdw_back.sv
// Back end: issues queued particles into three axis pipes, sums squares,
// keeps the running maximum and holds results in an output queue.
// Uses pdw_pkg and pdw_axis.
module pdw_back #(
	parameter int PW = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  pdw_pkg::cfg_t     cfg,
	input  logic              q_valid,
	input  logic [PW-1:0]     q_pos_x,
	input  logic [PW-1:0]     q_pos_y,
	input  logic [PW-1:0]     q_pos_z,
	input  pdw_pkg::vel_t     q_vel,
	output logic              q_take,
	input  logic              pop,
	output logic              empty,
	output logic [PW-1:0]     new_pos_x,
	output logic [PW-1:0]     new_pos_y,
	output logic [PW-1:0]     new_pos_z,
	output logic [63:0]       max_disp_sq,
	output logic              batch_end
);

	localparam int PIPE = 6;
	localparam int OAW  = $clog2(pdw_pkg::OUT_DEPTH);
	localparam int OCW  = $clog2(pdw_pkg::OUT_DEPTH + 1);

	pdw_pkg::span_t span_x, span_y, span_z;
	logic [PW-1:0]  ax_pos_x, ax_pos_y, ax_pos_z;
	logic [63:0]    ax_sq_x, ax_sq_y, ax_sq_z;

	logic [PIPE-1:0] vld_q;
	logic [PIPE-1:0] lst_q;
	logic [OCW-1:0]  crd_q;
	logic            pop_xfer;

	logic [PW-1:0]  px_s5, py_s5, pz_s5;
	logic [63:0]    sxy_s5, sz_s5;
	logic [PW-1:0]  px_s6, py_s6, pz_s6;
	logic [63:0]    rd_s6;
	logic [63:0]    max_q;
	logic [63:0]    new_max;

	logic [PW-1:0]  ox_q [pdw_pkg::OUT_DEPTH];
	logic [PW-1:0]  oy_q [pdw_pkg::OUT_DEPTH];
	logic [PW-1:0]  oz_q [pdw_pkg::OUT_DEPTH];
	logic [63:0]    om_q [pdw_pkg::OUT_DEPTH];
	logic           ol_q [pdw_pkg::OUT_DEPTH];
	logic [OAW-1:0] owr_q;
	logic [OAW-1:0] ord_q;
	logic [OCW-1:0] ocnt_q;
	logic           owr;

	assign span_x = pdw_pkg::box_span(cfg.box_x);
	assign span_y = pdw_pkg::box_span(cfg.box_y);
	assign span_z = pdw_pkg::box_span(cfg.box_z);

	// credits cover the pipe plus the output queue, so the pipe never stalls
	assign q_take   = q_valid && (crd_q != OCW'(pdw_pkg::OUT_DEPTH));
	assign empty    = (ocnt_q == '0);
	assign pop_xfer = pop && !empty;

	pdw_axis #(.PW(PW)) u_ax_x (
		.clk(clk), .pos(q_pos_x), .vel(q_vel.vel_x), .factor(cfg.drift_factor),
		.span(span_x), .new_pos(ax_pos_x), .sq(ax_sq_x)
	);
	pdw_axis #(.PW(PW)) u_ax_y (
		.clk(clk), .pos(q_pos_y), .vel(q_vel.vel_y), .factor(cfg.drift_factor),
		.span(span_y), .new_pos(ax_pos_y), .sq(ax_sq_y)
	);
	pdw_axis #(.PW(PW)) u_ax_z (
		.clk(clk), .pos(q_pos_z), .vel(q_vel.vel_z), .factor(cfg.drift_factor),
		.span(span_z), .new_pos(ax_pos_z), .sq(ax_sq_z)
	);

	always_ff @(posedge clk) begin
		lst_q  <= {lst_q[PIPE-2:0], q_vel.last};
		px_s5  <= ax_pos_x;
		py_s5  <= ax_pos_y;
		pz_s5  <= ax_pos_z;
		sxy_s5 <= pdw_pkg::sat_add(ax_sq_x, ax_sq_y);
		sz_s5  <= ax_sq_z;
		px_s6  <= px_s5;
		py_s6  <= py_s5;
		pz_s6  <= pz_s5;
		rd_s6  <= pdw_pkg::sat_add(sxy_s5, sz_s5);
	end

	assign owr     = vld_q[PIPE-1];
	assign new_max = (rd_s6 > max_q) ? rd_s6 : max_q;

	always_ff @(posedge clk) begin
		if (owr) begin
			ox_q[owr_q] <= px_s6;
			oy_q[owr_q] <= py_s6;
			oz_q[owr_q] <= pz_s6;
			om_q[owr_q] <= new_max;
			ol_q[owr_q] <= lst_q[PIPE-1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			crd_q  <= '0;
			max_q  <= '0;
			owr_q  <= '0;
			ord_q  <= '0;
			ocnt_q <= '0;
		end else begin
			vld_q <= {vld_q[PIPE-2:0], q_take};
			unique case ({q_take, pop_xfer})
				2'b10: crd_q <= crd_q + 1'b1;
				2'b01: crd_q <= crd_q - 1'b1;
				default: crd_q <= crd_q;
			endcase
			if (owr) begin
				owr_q <= owr_q + 1'b1;
				max_q <= lst_q[PIPE-1] ? '0 : new_max;
			end
			if (pop_xfer) begin
				ord_q <= ord_q + 1'b1;
			end
			unique case ({owr, pop_xfer})
				2'b10: ocnt_q <= ocnt_q + 1'b1;
				2'b01: ocnt_q <= ocnt_q - 1'b1;
				default: ocnt_q <= ocnt_q;
			endcase
		end
	end

	assign new_pos_x   = ox_q[ord_q];
	assign new_pos_y   = oy_q[ord_q];
	assign new_pos_z   = oz_q[ord_q];
	assign max_disp_sq = om_q[ord_q];
	assign batch_end   = ol_q[ord_q];

endmodule

FILE: rtl/pdw_checker.sv
// Port-level checks of the particle drift block, bound to the top level.
// Uses the macros of particle_drift_periodic_wrap_top_assert.svh.
`include "particle_drift_periodic_wrap_top_assert.svh"

module pdw_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        push,
	input logic        full,
	input logic        pop,
	input logic        empty,
	input logic [31:0] new_pos_x,
	input logic [63:0] max_disp_sq,
	input logic        batch_end,
	input logic        cfg_ready
);

	logic [4:0]  outst_q;
	logic        in_xfer;
	logic        out_xfer;
	logic        prev_ok_q;
	logic [63:0] prev_max_q;

	assign in_xfer  = push && !full;
	assign out_xfer = pop && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			outst_q    <= '0;
			prev_ok_q  <= 1'b0;
			prev_max_q <= '0;
		end else begin
			unique case ({in_xfer, out_xfer})
				2'b10: outst_q <= outst_q + 1'b1;
				2'b01: outst_q <= outst_q - 1'b1;
				default: outst_q <= outst_q;
			endcase
			if (out_xfer) begin
				prev_ok_q  <= !batch_end;
				prev_max_q <= max_disp_sq;
			end
		end
	end

	// no result without an item transferred in
	`PDW_ASSERT_NOW(a_no_spurious_result, !empty, outst_q != 5'd0)

	// the maximum never drops inside one batch
	`PDW_ASSERT_NOW(a_max_monotonic, out_xfer && prev_ok_q, max_disp_sq >= prev_max_q)

	`PDW_ASSERT_NOW(a_cfg_always_ready, 1'b1, cfg_ready)

	// a waiting result holds until taken
	`PDW_ASSERT_NEXT(a_result_holds, !empty && !pop, !empty && $stable(new_pos_x) && $stable(max_disp_sq))

endmodule

bind particle_drift_periodic_wrap_top pdw_checker u_pdw_checker (.*);

FILE: bench/testbench.sv
`timescale 1ns / 1ps
// Testbench of particle_drift_periodic_wrap_top: drift, periodic wrap and running maximum
// of squared displacement, predicted in-bench and checked per result transfer.
// Depends on pdw_pkg and the block's RTL.
module testbench;

	localparam int STALL_LIMIT  = 2000;
	localparam int DRAIN_CYCLES = 20;
	localparam int PHASES       = 8;
	localparam int PHASE_ITEMS  = 240;
	localparam int HOLD_CYCLES  = 80;
	localparam logic [pdw_pkg::CFG_IDX_W-1:0] CFG_SPARE = 3'd7;

	typedef struct packed {
		logic [31:0]        pos_x;
		logic [31:0]        pos_y;
		logic [31:0]        pos_z;
		logic signed [31:0] vel_x;
		logic signed [31:0] vel_y;
		logic signed [31:0] vel_z;
		logic               last;
	} particle_t;

	typedef struct packed {
		logic [31:0] new_pos_x;
		logic [31:0] new_pos_y;
		logic [31:0] new_pos_z;
		logic [63:0] max_disp_sq;
		logic        batch_end;
	} moved_t;

	class drift_predictor;
		logic [31:0] factor;
		logic [12:0] cells_x;
		logic [12:0] cells_y;
		logic [12:0] cells_z;
		logic [63:0] peak_sq;
		moved_t      expected_moves[$];
		int unsigned errors;

		function new();
			factor  = pdw_pkg::DRIFT_RESET;
			cells_x = pdw_pkg::BOX_RESET;
			cells_y = pdw_pkg::BOX_RESET;
			cells_z = pdw_pkg::BOX_RESET;
			peak_sq = '0;
			errors  = 0;
		endfunction

		function void write_reg(logic [pdw_pkg::CFG_IDX_W-1:0] index, logic [31:0] data);
			case (index)
				pdw_pkg::CFG_DRIFT_FACTOR: factor = data;
				pdw_pkg::CFG_BOX_X:        cells_x = data[12:0];
				pdw_pkg::CFG_BOX_Y:        cells_y = data[12:0];
				pdw_pkg::CFG_BOX_Z:        cells_z = data[12:0];
				default: ;
			endcase
		endfunction

		// box length in Q20, zero treated as one cell, clamped at the largest box
		function logic [63:0] span_of(logic [12:0] cells);
			logic [12:0] c;
			if (cells == 13'd0) begin
				c = 13'd1;
			end else if (cells > 13'(pdw_pkg::MAX_BOX)) begin
				c = 13'(pdw_pkg::MAX_BOX);
			end else begin
				c = cells;
			end
			return 64'(c) << pdw_pkg::FRAC_BITS;
		endfunction

		function logic [63:0] sum_sat(logic [63:0] a, logic [63:0] b);
			logic [64:0] t;
			t = {1'b0, a} + {1'b0, b};
			return t[64] ? {64{1'b1}} : t[63:0];
		endfunction

		function logic [31:0] move_axis(logic [31:0] pos, logic [31:0] vel, logic [12:0] cells,
				output logic [63:0] sq);
			logic signed [63:0] prod;
			logic signed [63:0] step;
			logic signed [63:0] sspan;
			logic signed [63:0] sum;
			logic [63:0]        mag;
			sspan = $signed(span_of(cells));
			prod  = $signed({{32{vel[31]}}, vel}) * $signed({32'b0, factor});
			step  = prod >>> pdw_pkg::FACT_FRAC;  // floor toward minus infinity
			if (step > sspan)
				step = sspan;
			if (step < -sspan)
				step = -sspan;
			mag = (step < 0) ? 64'(-step) : 64'(step);
			sq  = (mag > 64'hFFFF_FFFF) ? {64{1'b1}} : mag * mag;
			sum = $signed({32'b0, pos}) + step;
			// single wrap only; positions past the box may stay outside
			if (sum < 0) begin
				sum = sum + sspan;
			end else if (sum >= sspan) begin
				sum = sum - sspan;
			end
			return sum[31:0];
		endfunction

		function void note_particle(particle_t p);
			moved_t      m;
			logic [63:0] sx;
			logic [63:0] sy;
			logic [63:0] sz;
			logic [63:0] total;
			m.new_pos_x = move_axis(p.pos_x, p.vel_x, cells_x, sx);
			m.new_pos_y = move_axis(p.pos_y, p.vel_y, cells_y, sy);
			m.new_pos_z = move_axis(p.pos_z, p.vel_z, cells_z, sz);
			total = sum_sat(sum_sat(sx, sy), sz);
			if (total > peak_sq)
				peak_sq = total;
			m.max_disp_sq = peak_sq;
			m.batch_end   = p.last;
			if (p.last)
				peak_sq = '0;
			expected_moves.push_back(m);
		endfunction

		function void compare_field(string name, logic [63:0] want, logic [63:0] got);
			if (got !== want) begin
				$error("%s: expected %0h, got %0h", name, want, got);
				errors++;
			end
		endfunction

		function void check_result(moved_t got);
			moved_t want;
			if (expected_moves.size() == 0) begin
				$error("result transfer with nothing expected");
				errors++;
				return;
			end
			want = expected_moves.pop_front();
			compare_field("new_pos_x", 64'(want.new_pos_x), 64'(got.new_pos_x));
			compare_field("new_pos_y", 64'(want.new_pos_y), 64'(got.new_pos_y));
			compare_field("new_pos_z", 64'(want.new_pos_z), 64'(got.new_pos_z));
			compare_field("max_disp_sq", want.max_disp_sq, got.max_disp_sq);
			compare_field("batch_end", 64'(want.batch_end), 64'(got.batch_end));
		endfunction

		function int pending();
			return expected_moves.size();
		endfunction
	endclass

	logic                          clk;
	logic                          arst_n;
	logic                          push;
	logic                          full;
	logic [31:0]                   pos_x;
	logic [31:0]                   pos_y;
	logic [31:0]                   pos_z;
	logic signed [31:0]            vel_x;
	logic signed [31:0]            vel_y;
	logic signed [31:0]            vel_z;
	logic                          last;
	logic                          empty;
	logic                          pop;
	logic [31:0]                   new_pos_x;
	logic [31:0]                   new_pos_y;
	logic [31:0]                   new_pos_z;
	logic [63:0]                   max_disp_sq;
	logic                          batch_end;
	logic                          cfg_valid;
	logic                          cfg_ready;
	logic [pdw_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [31:0]                   cfg_data;

	int unsigned send_idle_pct  = 0;
	int unsigned recv_stall_pct = 0;
	int          hold_left      = 0;
	int          quiet_cycles   = 0;

	drift_predictor drift_pred = new();

	particle_drift_periodic_wrap_top u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.pos_x       (pos_x),
		.pos_y       (pos_y),
		.pos_z       (pos_z),
		.vel_x       (vel_x),
		.vel_y       (vel_y),
		.vel_z       (vel_z),
		.last        (last),
		.empty       (empty),
		.pop         (pop),
		.new_pos_x   (new_pos_x),
		.new_pos_y   (new_pos_y),
		.new_pos_z   (new_pos_z),
		.max_disp_sq (max_disp_sq),
		.batch_end   (batch_end),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic particle_t make_particle(logic [31:0] px, logic [31:0] py,
			logic [31:0] pz, logic [31:0] vx, logic [31:0] vy, logic [31:0] vz, logic lst);
		particle_t p;
		p = '{px, py, pz, vx, vy, vz, lst};
		return p;
	endfunction

	function automatic logic [31:0] pick_pos(logic [63:0] span);
		case ($urandom_range(0, 9))
			0: return 32'h0;
			1: return 32'hFFFF_FFFF;
			2: return 32'(span - 1);
			3: return 32'(span);
			4, 5: return $urandom;
			default: return $urandom_range(0, 32'(span - 1));
		endcase
	endfunction

	function automatic logic [31:0] pick_vel();
		case ($urandom_range(0, 9))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
			3, 4, 5: return $urandom;
			// spread of magnitudes, most small enough to stay inside the box
			default: return 32'($signed($urandom) >>> $urandom_range(4, 31));
		endcase
	endfunction

	function automatic particle_t random_particle();
		particle_t p;
		p.pos_x = pick_pos(drift_pred.span_of(drift_pred.cells_x));
		p.pos_y = pick_pos(drift_pred.span_of(drift_pred.cells_y));
		p.pos_z = pick_pos(drift_pred.span_of(drift_pred.cells_z));
		p.vel_x = pick_vel();
		p.vel_y = pick_vel();
		p.vel_z = pick_vel();
		p.last  = ($urandom_range(0, 9) == 0);
		return p;
	endfunction

	function automatic logic [31:0] pick_factor();
		case ($urandom_range(0, 4))
			0: return 32'h0;
			1: return 32'hFFFF_FFFF;
			2: return pdw_pkg::DRIFT_RESET;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [31:0] pick_box();
		case ($urandom_range(0, 4))
			0: return 32'd1;
			1: return 32'(pdw_pkg::MAX_BOX);
			2: return $urandom;  // upper bits ignored, may land out of range
			default: return $urandom_range(1, pdw_pkg::MAX_BOX);
		endcase
	endfunction

	task automatic send_particle(particle_t p);
		@(negedge clk);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			push <= 1'b0;
			@(negedge clk);
		end
		push  <= 1'b1;
		pos_x <= p.pos_x;
		pos_y <= p.pos_y;
		pos_z <= p.pos_z;
		vel_x <= p.vel_x;
		vel_y <= p.vel_y;
		vel_z <= p.vel_z;
		last  <= p.last;
		forever begin
			@(posedge clk);
			if (!full)
				break;
		end
		drift_pred.note_particle(p);
	endtask

	task automatic stop_sending();
		@(negedge clk);
		push <= 1'b0;
	endtask

	task automatic write_reg(logic [pdw_pkg::CFG_IDX_W-1:0] index, logic [31:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= index;
		cfg_data  <= data;
		forever begin
			@(posedge clk);
			if (cfg_ready)
				break;
		end
		drift_pred.write_reg(index, data);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic wait_drained();
		while (drift_pred.pending() != 0)
			@(posedge clk);
	endtask

	// result side: random stalls, plus a long hold-off on request
	initial begin
		moved_t got;
		pop = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				pop <= 1'b0;
				hold_left--;
			end else begin
				pop <= ($urandom_range(0, 99) >= recv_stall_pct);
			end
			@(posedge clk);
			if (pop && !empty) begin
				got = '{new_pos_x, new_pos_y, new_pos_z, max_disp_sq, batch_end};
				drift_pred.check_result(got);
			end
		end
	end

	// watchdog on cycles with no transfer on any channel
	initial begin
		while (quiet_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("testbench NOT OK");
		$finish;
	end

	initial begin
		arst_n    = 1'b0;
		push      = 1'b0;
		pos_x     = '0;
		pos_y     = '0;
		pos_z     = '0;
		vel_x     = '0;
		vel_y     = '0;
		vel_z     = '0;
		last      = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset settings: unit factor, 256-cell box
		send_particle(make_particle(32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0));
		send_particle(make_particle(32'h0, 32'h0FFF_FFFF, 32'hFFFF_FFFF,
			32'hFFFF_FFFF, 32'h0000_0001, 32'h0, 1'b0));
		send_particle(make_particle(32'h0, 32'h0, 32'h0FFF_FFFF,
			32'h7FFF_FFFF, 32'h8000_0000, 32'h0010_0000, 1'b0));
		send_particle(make_particle(32'h0001_E240, 32'h00AB_CDEF, 32'h0FFF_FFFF,
			32'h0010_0000, 32'hFFF0_0000, 32'h0, 1'b1));
		send_particle(make_particle(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
			32'h1, 32'h1, 32'h1, 1'b0));
		send_particle(make_particle(32'h0800_0000, 32'h0, 32'h0,
			32'h0000_0400, 32'h0, 32'h0, 1'b1));
		stop_sending();
		wait_drained();

		// largest factor and box: displacement saturates at 2^32, square overflows
		write_reg(pdw_pkg::CFG_DRIFT_FACTOR, 32'hFFFF_FFFF);
		write_reg(pdw_pkg::CFG_BOX_X, 32'(pdw_pkg::MAX_BOX));
		write_reg(pdw_pkg::CFG_BOX_Y, 32'(pdw_pkg::MAX_BOX));
		write_reg(pdw_pkg::CFG_BOX_Z, 32'(pdw_pkg::MAX_BOX));
		send_particle(make_particle(32'hFFFF_FFFF, 32'h0, 32'h8000_0000,
			32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0100, 1'b0));
		send_particle(make_particle(32'h0, 32'h0, 32'h0,
			32'h1, 32'hFFFF_FFFF, 32'h0, 1'b1));
		send_particle(make_particle(32'h1234_5678, 32'h9ABC_DEF0, 32'h0F0F_0F0F,
			32'h0000_1000, 32'hFFFF_F000, 32'h0123_4567, 1'b0));
		stop_sending();
		wait_drained();

		// zero factor, box register of zero and out of range, spare index
		write_reg(pdw_pkg::CFG_DRIFT_FACTOR, 32'h0);
		write_reg(pdw_pkg::CFG_BOX_X, 32'hFFFF_E000);
		write_reg(pdw_pkg::CFG_BOX_Y, 32'h0000_1FFF);
		write_reg(pdw_pkg::CFG_BOX_Z, 32'h1);
		write_reg(CFG_SPARE, 32'hFFFF_FFFF);
		send_particle(make_particle(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0010_0000,
			32'h7FFF_FFFF, 32'h8000_0000, 32'h1234_5678, 1'b1));
		send_particle(make_particle(32'h000F_FFFF, 32'h0, 32'h0,
			32'h0, 32'h0, 32'h0, 1'b0));
		stop_sending();
		wait_drained();

		// one-cell boxes on x and z with unit factor
		write_reg(pdw_pkg::CFG_DRIFT_FACTOR, pdw_pkg::DRIFT_RESET);
		send_particle(make_particle(32'h0, 32'h000F_FFFF, 32'h000F_FFFF,
			32'hFFFF_FFFF, 32'h0000_0001, 32'hFFF0_0000, 1'b1));
		stop_sending();

		for (int ph = 0; ph < PHASES; ph++) begin
			wait_drained();
			write_reg(pdw_pkg::CFG_DRIFT_FACTOR, pick_factor());
			write_reg(pdw_pkg::CFG_BOX_X, pick_box());
			write_reg(pdw_pkg::CFG_BOX_Y, pick_box());
			write_reg(pdw_pkg::CFG_BOX_Z, pick_box());
			case (ph % 4)
				0: begin
					send_idle_pct  = 0;
					recv_stall_pct = 0;
				end
				1: begin
					send_idle_pct  = 50;
					recv_stall_pct = 0;
				end
				2: begin
					send_idle_pct  = 0;
					recv_stall_pct = 50;
				end
				default: begin
					send_idle_pct  = 9;
					recv_stall_pct = 9;
				end
			endcase
			// long result-side hold so the block backs up into full
			if (ph == 4)
				hold_left = HOLD_CYCLES;
			repeat (PHASE_ITEMS)
				send_particle(random_particle());
			stop_sending();
		end

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (drift_pred.errors == 0)
			$display("testbench OK");
		else
			$display("testbench NOT OK");
		$finish;
	end

endmodule

FILE: sim.f
+incdir+rtl
rtl/pdw_pkg.sv
rtl/pdw_front.sv
rtl/pdw_axis.sv
rtl/pdw_back.sv
rtl/particle_drift_periodic_wrap_top.sv
rtl/pdw_checker.sv
bench/testbench.sv
